/* hdl/centre_weighted_median_3x3_unit_defines.svh */
// assertion helpers used by the top-level rtl
`ifndef CENTRE_WEIGHTED_MEDIAN_3X3_UNIT_DEFINES_SVH
`define CENTRE_WEIGHTED_MEDIAN_3X3_UNIT_DEFINES_SVH

// same-cycle implication
`define CWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwm check failed");

// next-cycle implication
`define CWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwm check failed");

`endif

/* hdl/cwm_pkg.sv */
`timescale 1ns / 1ps
package cwm_pkg;

    localparam int PIX_W     = 8;
    localparam int STR_W     = 4;
    localparam int LW_W      = 12;
    localparam int FH_W      = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int WIN_N     = 9;
    localparam int CENTRE    = 4;
    localparam int RANK_W    = 5;
    localparam int HT_MAX    = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [STR_W-1:0] STRENGTH_RST     = 4'd5;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST   = 12'd2048;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 13'd1080;

    typedef logic signed [PIX_W-1:0] t_pix;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_pix t2;
        t_pix t1;
        t_pix t0;
    } t_row;

    typedef struct packed {
        logic op;
        t_pix pixel_in;
    } t_in_item;

    typedef struct packed {
        t_pix pixel_out;
        logic end_of_frame;
    } t_out_item;

    function automatic logic [STR_W-1:0] f_centre_weight(input logic [STR_W-1:0] s);
        logic [STR_W-1:0] w;
        if (s >= 4'd9) begin
            w = 4'd1;
        end else begin
            w = 4'd10 - s;
        end
        return w;
    endfunction

endpackage

/* hdl/cwm_cell.sv */
`timescale 1ns / 1ps
module cwm_cell
    import cwm_pkg::*;
#(
    parameter bit HAS_LINE   = 1'b1,
    parameter int LINE_DEPTH = 2047
) (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic [$clog2(LINE_DEPTH)-1:0] i_ptr,
    input  t_pix                          i_din,
    output t_row                          o_row,
    output t_pix                          o_line
);

    t_row r_row;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_row.t0 <= i_din;
            r_row.t1 <= r_row.t0;
            r_row.t2 <= r_row.t1;
        end
    end

    assign o_row = r_row;

    generate
        if (HAS_LINE) begin : g_line
            // line delay: w-1 entries plus the read register
            t_pix r_mem [LINE_DEPTH];
            t_pix r_line;

            always_ff @(posedge i_clk) begin
                if (i_shift) begin
                    r_line       <= r_mem[i_ptr];
                    r_mem[i_ptr] <= i_din;
                end
            end

            assign o_line = r_line;
        end else begin : g_no_line
            assign o_line = '0;
        end
    endgenerate

endmodule

/* hdl/cwm_median.sv */
`timescale 1ns / 1ps
module cwm_median
    import cwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_load,
    input  t_win             i_win,
    input  logic [STR_W-1:0] i_cw,
    output t_pix             o_value
);

    t_win                              r_win;
    logic [WIN_N-1:0][RANK_W-1:0]      r_lt;
    logic [WIN_N-1:0][RANK_W-1:0]      n_lt;
    logic [STR_W-1:0]                  r_cw;
    logic [RANK_W-1:0]                 r_ka;
    logic [RANK_W-1:0]                 r_kb;
    logic [RANK_W-1:0]                 n_ka;
    logic [RANK_W-1:0]                 n_kb;
    t_pix                              w_a;
    t_pix                              w_b;
    logic signed [PIX_W+1:0]           w_sum;

    // weighted rank of each sample, ties broken by position
    always_comb begin
        logic ahead;
        for (int i = 0; i < WIN_N; i++) begin
            n_lt[i] = '0;
            for (int j = 0; j < WIN_N; j++) begin
                ahead = ($signed(i_win[j]) < $signed(i_win[i]))
                     || ((i_win[j] == i_win[i]) && (j < i));
                if ((j != i) && ahead) begin
                    if (j == CENTRE) begin
                        n_lt[i] = n_lt[i] + RANK_W'(i_cw);
                    end else begin
                        n_lt[i] = n_lt[i] + RANK_W'(1);
                    end
                end
            end
        end
        n_ka = (RANK_W'(i_cw) + RANK_W'(7)) >> 1;
        n_kb = (RANK_W'(i_cw) + RANK_W'(8)) >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= i_win;
            r_lt  <= n_lt;
            r_cw  <= i_cw;
            r_ka  <= n_ka;
            r_kb  <= n_kb;
        end
    end

    always_comb begin
        logic [RANK_W-1:0] wt;
        w_a = '0;
        w_b = '0;
        for (int i = 0; i < WIN_N; i++) begin
            wt = (i == CENTRE) ? RANK_W'(r_cw) : RANK_W'(1);
            if ((r_lt[i] <= r_ka) && (r_ka < r_lt[i] + wt)) begin
                w_a = r_win[i];
            end
            if ((r_lt[i] <= r_kb) && (r_kb < r_lt[i] + wt)) begin
                w_b = r_win[i];
            end
        end
    end

    assign w_sum   = (PIX_W+2)'(w_a) + (PIX_W+2)'(w_b) + (PIX_W+2)'(1);
    assign o_value = PIX_W'(w_sum >>> 1);

endmodule

/* hdl/centre_weighted_median_3x3_unit.sv */
`timescale 1ns / 1ps
// Centre-weighted 3x3 median over a raster stream of signed pixels. One item is
// taken per clock while o_in_ready is high; the result released by an item
// passes through the s1, s2 and output registers, and stalls only back up
// when all three pipeline stages hold results. Each pixel comes out
// line_width+1 items after it went in; at the end of a frame, flush items
// (op=1) drain those pending pixels one per flush. A row of three cells
// holds the window, two of them with a line memory of MAX_WIDTH-1 samples;
// a pending-sample memory supplies border pixels, which pass unchanged. Writing
// line_width or frame_height restarts the stream and drops pending output.
`include "centre_weighted_median_3x3_unit_defines.svh"
module centre_weighted_median_3x3_unit
    import cwm_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int PW         = $clog2(MAX_WIDTH + 2);
    localparam int CW         = (WW > LW_W) ? WW : LW_W;
    localparam int LINE_DEPTH = MAX_WIDTH - 1;
    localparam int LAW        = $clog2(LINE_DEPTH);

    logic [STR_W-1:0] r_strength;
    logic [LW_W-1:0]  r_line_width;
    logic [FH_W-1:0]  r_frame_height;

    logic [WW-1:0]    r_col;
    logic [FH_W-1:0]  r_row;
    logic [WW-1:0]    r_ocol;
    logic [FH_W-1:0]  r_orow;
    logic [PW-1:0]    r_pend;
    logic [PW-1:0]    r_wp;
    logic [LAW-1:0]   r_lptr;

    t_pix             r_fifo [2**PW];

    logic             r_s1_valid;
    logic             r_s1_int;
    logic             r_s1_eof;
    logic [STR_W-1:0] r_s1_cw;
    t_pix             r_s1_pass;
    logic             r_s2_valid;
    logic             r_s2_int;
    logic             r_s2_eof;
    t_pix             r_s2_pass;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [CW-1:0]    w_lw_x;
    logic [WW-1:0]    w_eff_w;
    logic [FH_W-1:0]  w_eff_h;
    logic             w_out_en;
    logic             w_s2_en;
    logic             w_s1_en;
    logic             w_accept;
    logic             w_is_pix;
    logic             w_emit;
    logic             w_int;
    logic             w_eof;
    logic             w_cfg_we;
    logic             w_restart;
    logic [PW-1:0]    w_rd_addr;
    t_row             w_row0;
    t_row             w_row1;
    t_row             w_row2;
    t_pix             w_line0;
    t_pix             w_line1;
    t_win             w_win;
    t_pix             w_med;

    // clamped geometry
    assign w_lw_x = CW'(r_line_width);
    always_comb begin
        if (w_lw_x < CW'(3)) begin
            w_eff_w = WW'(3);
        end else if (w_lw_x > CW'(MAX_WIDTH)) begin
            w_eff_w = WW'(MAX_WIDTH);
        end else begin
            w_eff_w = WW'(w_lw_x);
        end
        if (r_frame_height < FH_W'(3)) begin
            w_eff_h = FH_W'(3);
        end else if (r_frame_height > FH_W'(HT_MAX)) begin
            w_eff_h = FH_W'(HT_MAX);
        end else begin
            w_eff_h = r_frame_height;
        end
    end

    assign w_out_en   = !r_out_valid || i_out_ready;
    assign w_s2_en    = !r_s2_valid || w_out_en;
    assign w_s1_en    = !r_s1_valid || w_s2_en;
    assign o_in_ready = w_s1_en;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_pix   = !i_in_item.op;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_restart   = w_cfg_we
                      && ((i_cfg_index == CFG_LINE_WIDTH) || (i_cfg_index == CFG_FRAME_HEIGHT));

    always_comb begin
        if (w_is_pix) begin
            w_emit = (r_pend >= PW'(w_eff_w) + PW'(1));
        end else begin
            w_emit = (r_col == '0) && (r_row == '0) && (r_pend != '0);
        end
        w_int = (r_orow != '0) && (r_ocol != '0)
             && (r_orow + FH_W'(1) < w_eff_h)
             && (PW'(r_ocol) + PW'(1) < PW'(w_eff_w));
        w_eof = (r_orow == w_eff_h - FH_W'(1)) && (r_ocol == w_eff_w - WW'(1));
    end

    assign w_rd_addr = r_wp - r_pend;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength     <= STRENGTH_RST;
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_STRENGTH:     r_strength     <= i_cfg_data[STR_W-1:0];
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stream position and pending count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_pend <= '0;
            r_lptr <= '0;
        end else if (w_accept) begin
            if (w_is_pix) begin
                if (r_col == w_eff_w - WW'(1)) begin
                    r_col <= '0;
                    r_row <= (r_row == w_eff_h - FH_W'(1)) ? '0 : r_row + FH_W'(1);
                end else begin
                    r_col <= r_col + WW'(1);
                end
                if (WW'(r_lptr) >= w_eff_w - WW'(2)) begin
                    r_lptr <= '0;
                end else begin
                    r_lptr <= r_lptr + LAW'(1);
                end
            end
            if (w_emit) begin
                if (r_ocol == w_eff_w - WW'(1)) begin
                    r_ocol <= '0;
                    r_orow <= (r_orow == w_eff_h - FH_W'(1)) ? '0 : r_orow + FH_W'(1);
                end else begin
                    r_ocol <= r_ocol + WW'(1);
                end
            end
            if (w_is_pix && !w_emit) begin
                r_pend <= r_pend + PW'(1);
            end else if (!w_is_pix && w_emit) begin
                r_pend <= r_pend - PW'(1);
            end
        end
    end

    // pending samples, read for border pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (w_accept && w_is_pix) begin
            r_wp <= r_wp + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_pix) begin
            r_fifo[r_wp] <= i_in_item.pixel_in;
        end
        if (w_accept && w_emit) begin
            r_s1_pass <= r_fifo[w_rd_addr];
        end
    end

    cwm_cell #(.HAS_LINE(1'b1), .LINE_DEPTH(LINE_DEPTH)) u_cell0 (
        .i_clk   (i_clk),
        .i_shift (w_accept && w_is_pix),
        .i_ptr   (r_lptr),
        .i_din   (i_in_item.pixel_in),
        .o_row   (w_row0),
        .o_line  (w_line0)
    );

    cwm_cell #(.HAS_LINE(1'b1), .LINE_DEPTH(LINE_DEPTH)) u_cell1 (
        .i_clk   (i_clk),
        .i_shift (w_accept && w_is_pix),
        .i_ptr   (r_lptr),
        .i_din   (w_line0),
        .o_row   (w_row1),
        .o_line  (w_line1)
    );

    cwm_cell #(.HAS_LINE(1'b0), .LINE_DEPTH(LINE_DEPTH)) u_cell2 (
        .i_clk   (i_clk),
        .i_shift (w_accept && w_is_pix),
        .i_ptr   (r_lptr),
        .i_din   (w_line1),
        .o_row   (w_row2),
        .o_line  ()
    );

    assign w_win = {w_row0.t0, w_row0.t1, w_row0.t2,
                    w_row1.t0, w_row1.t1, w_row1.t2,
                    w_row2.t0, w_row2.t1, w_row2.t2};

    cwm_median u_median (
        .i_clk   (i_clk),
        .i_load  (w_s2_en && r_s1_valid),
        .i_win   (w_win),
        .i_cw    (r_s1_cw),
        .o_value (w_med)
    );

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= w_accept && w_emit;
            end
            if (w_s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_en) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_s1_int <= w_int;
            r_s1_eof <= w_eof;
            r_s1_cw  <= f_centre_weight(r_strength);
        end
        if (w_s2_en && r_s1_valid) begin
            r_s2_int  <= r_s1_int;
            r_s2_eof  <= r_s1_eof;
            r_s2_pass <= r_s1_pass;
        end
        if (w_out_en && r_s2_valid) begin
            r_out_item.pixel_out    <= r_s2_int ? w_med : r_s2_pass;
            r_out_item.end_of_frame <= r_s2_eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `CWM_ASSERT_IMP(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend <= PW'(w_eff_w) + PW'(1))
    `CWM_ASSERT_NEXT(a_flush_border, i_clk, i_rst_n, w_accept && !w_is_pix, !(r_s1_valid && r_s1_int))
    `CWM_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !o_in_ready, r_s1_valid && r_s2_valid && r_out_valid)

endmodule
